// File: src/fsms_pkg.sv
// shared types, constants and helpers of the fail signature match scorer
package fsms_pkg;

   localparam int unsigned DATA_BITS     = 64;
   localparam int unsigned DEF_WORD_BITS = 64;
   localparam int unsigned CNT_BITS      = 20;
   localparam int unsigned NUM_CNT       = 9;
   localparam int unsigned PCNT_BITS     = $clog2(DATA_BITS + 1);
   localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

   // counter order follows the totals fields of a result
   localparam int unsigned CNT_SLAT_FF   = 0;
   localparam int unsigned CNT_SLAT_SIM  = 1;
   localparam int unsigned CNT_SLAT_OBS  = 2;
   localparam int unsigned CNT_SPLAT_FF  = 3;
   localparam int unsigned CNT_SPLAT_SIM = 4;
   localparam int unsigned CNT_SPLAT_OBS = 5;
   localparam int unsigned CNT_BIT_FF    = 6;
   localparam int unsigned CNT_BIT_SIM   = 7;
   localparam int unsigned CNT_BIT_OBS   = 8;

   typedef logic [DATA_BITS-1:0] data_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;
   typedef cnt_type [NUM_CNT-1:0] cnt_vec_type;

   typedef enum logic [1:0] {
      KIND_SIG,
      KIND_SLAT,
      KIND_SPLAT,
      KIND_TOTALS
   } kind_type;

   typedef struct packed {
      logic               clear;
      logic [NUM_CNT-1:0] add_en;
   } cnt_upd_type;

   function automatic logic [PCNT_BITS-1:0] popcount(input data_type v);
      logic [PCNT_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < DATA_BITS; i++) begin
         n = n + PCNT_BITS'(v[i]);
      end
      return n;
   endfunction

endpackage

// File: src/fsms_if.sv
// item channels of the scorer: request and response interfaces
interface fsms_req_if;
   logic                 valid;
   logic                 ready;
   fsms_pkg::data_type   good_word;
   fsms_pkg::data_type   faulty_word;
   fsms_pkg::data_type   observed_word;
   fsms_pkg::data_type   observed_any;
   fsms_pkg::data_type   valid_mask;
   logic                 last_output;
   logic                 last_chunk;

   modport source (
      output valid, good_word, faulty_word, observed_word, observed_any, valid_mask,
             last_output, last_chunk,
      input  ready
   );
   modport sink (
      input  valid, good_word, faulty_word, observed_word, observed_any, valid_mask,
             last_output, last_chunk,
      output ready
   );
endinterface

interface fsms_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   fsms_pkg::data_type   word;
   fsms_pkg::cnt_type    slat_fail_fail;
   fsms_pkg::cnt_type    slat_sim_only;
   fsms_pkg::cnt_type    slat_obs_only;
   fsms_pkg::cnt_type    splat_fail_fail;
   fsms_pkg::cnt_type    splat_sim_only;
   fsms_pkg::cnt_type    splat_obs_only;
   fsms_pkg::cnt_type    bit_fail_fail;
   fsms_pkg::cnt_type    bit_sim_only;
   fsms_pkg::cnt_type    bit_obs_only;
   logic                 last_result;

   modport source (
      output valid, kind, word, slat_fail_fail, slat_sim_only, slat_obs_only,
             splat_fail_fail, splat_sim_only, splat_obs_only,
             bit_fail_fail, bit_sim_only, bit_obs_only, last_result,
      input  ready
   );
   modport sink (
      input  valid, kind, word, slat_fail_fail, slat_sim_only, slat_obs_only,
             splat_fail_fail, splat_sim_only, splat_obs_only,
             bit_fail_fail, bit_sim_only, bit_obs_only, last_result,
      output ready
   );
endinterface

// File: src/fsms_counters.sv
// bank of nine saturating total counters with clear and per-counter add
module fsms_counters (
   input  logic                  clock,
   input  logic                  reset,
   input  fsms_pkg::cnt_upd_type upd,
   input  fsms_pkg::cnt_vec_type amount,
   output fsms_pkg::cnt_vec_type total
);

   fsms_pkg::cnt_vec_type cnt_ff;
   fsms_pkg::cnt_vec_type cnt_in;

   always_comb begin
      logic [fsms_pkg::CNT_BITS:0] sum;
      fsms_pkg::cnt_type           base;
      sum  = '0;
      base = '0;
      for (int i = 0; i < fsms_pkg::NUM_CNT; i++) begin
         // a clear and a new add in the same cycle start from zero
         base = upd.clear ? '0 : cnt_ff[i];
         sum  = {1'b0, base} + {1'b0, amount[i]};
         if (upd.add_en[i]) begin
            cnt_in[i] = (sum > {1'b0, fsms_pkg::CNT_MAX}) ? fsms_pkg::CNT_MAX
                                                           : sum[fsms_pkg::CNT_BITS-1:0];
         end else begin
            cnt_in[i] = base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign total = cnt_ff;

endmodule

// File: src/fail_signature_match_scorer.sv
// top level of the fail signature match scorer
//
// req_bus takes one item per output and pattern chunk: good and faulty
// simulated words, the observed fail word, the chunk's any-fail word, the
// valid-pattern mask and the last-output and last-chunk marks. rsp_bus
// returns the results, one per cycle unless stalled, last_result set on the final one.
// Every item gives its fail signature (kind 0). An item with last_output
// also gives the slat and splat masks (kinds 1 and 2); with last_chunk as
// well it gives the nine totals (kind 3) and the counters clear.
// The first result is offered once its item has passed the input register,
// scoring stage and result register. Items with no chunk end go through
// at one per cycle while rsp_bus is not stalled; a chunk end holds the
// scoring stage until it has handed out its three results, or four when
// it ends the candidate, one result per cycle unless stalled.
// A stalled rsp_bus holds its result; the scoring stage and the input
// register still fill, and req_bus drops ready once both are full.
// Reset empties all stages, sets the match masks to all ones and clears
// the any-fail word and every counter.
module fail_signature_match_scorer #(
   parameter int unsigned WORD_BITS = fsms_pkg::DEF_WORD_BITS
) (
   input logic        clock,
   input logic        reset,
   fsms_req_if.sink   req_bus,
   fsms_rsp_if.source rsp_bus
);

   typedef logic [WORD_BITS-1:0] wrd_type;

   // input register
   logic    s1_valid_ff, s1_valid_in;
   wrd_type s1_good_ff, s1_faulty_ff, s1_obs_ff, s1_obs_any_ff, s1_vmask_ff;
   logic    s1_last_out_ff, s1_last_chk_ff;

   // chunk accumulators
   wrd_type exact_acc_ff, exact_acc_in;
   wrd_type subset_acc_ff, subset_acc_in;
   wrd_type sim_any_acc_ff, sim_any_acc_in;

   // scoring stage
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_pend_ff, s2_pend_in;
   fsms_pkg::kind_type s2_kind_ff, s2_kind_in;
   wrd_type            s2_sim_ff, s2_slat_ff, s2_splat_ff;
   wrd_type            s2_sim_any_ff, s2_obs_any_ff, s2_vmask_ff;
   logic               s2_last_out_ff, s2_last_chk_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   fsms_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   fsms_pkg::data_type rsp_word_ff, rsp_word_in;
   fsms_pkg::cnt_vec_type rsp_cnt_ff, rsp_cnt_in;
   logic               rsp_last_ff, rsp_last_in;

   logic    req_accept, s1_move, out_free, out_load, s2_final, s2_done, s2_take;
   wrd_type sim, exact_new, subset_new, sim_any_new, slat_new, splat_new;

   fsms_pkg::cnt_upd_type cnt_upd;
   fsms_pkg::cnt_vec_type cnt_amount;
   fsms_pkg::cnt_vec_type cnt_total;

   // handshake and stage movement
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign out_load      = s2_valid_ff && out_free;
   assign s2_done       = out_load && s2_final;
   assign s2_take       = !s2_valid_ff || s2_done;
   assign s1_move       = s1_valid_ff && s2_take;
   assign req_bus.ready = !s1_valid_ff || s2_take;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign s1_valid_in = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s1_move ? 1'b1 : (s2_done ? 1'b0 : s2_valid_ff);
   // chunk counts go in during the first cycle a chunk end sits in the stage
   assign s2_pend_in  = s1_move && s1_last_out_ff;

   // scoring of the item in the input register
   always_comb begin
      sim         = (s1_good_ff ^ s1_faulty_ff) & s1_vmask_ff;
      exact_new   = exact_acc_ff & ~(sim ^ s1_obs_ff);
      subset_new  = subset_acc_ff & ~(sim & ~s1_obs_ff);
      sim_any_new = sim_any_acc_ff | sim;
      slat_new    = exact_new & s1_vmask_ff & s1_obs_any_ff & sim_any_new;
      splat_new   = subset_new & s1_vmask_ff & s1_obs_any_ff & sim_any_new;
      if (s1_move && s1_last_out_ff) begin
         exact_acc_in   = '1;
         subset_acc_in  = '1;
         sim_any_acc_in = '0;
      end else if (s1_move) begin
         exact_acc_in   = exact_new;
         subset_acc_in  = subset_new;
         sim_any_acc_in = sim_any_new;
      end else begin
         exact_acc_in   = exact_acc_ff;
         subset_acc_in  = subset_acc_ff;
         sim_any_acc_in = sim_any_acc_ff;
      end
   end

   // counter updates
   always_comb begin
      cnt_upd.clear  = out_load && (s2_kind_ff == fsms_pkg::KIND_TOTALS);
      cnt_upd.add_en = '0;
      cnt_upd.add_en[fsms_pkg::CNT_BIT_FF]    = s1_move;
      cnt_upd.add_en[fsms_pkg::CNT_BIT_SIM]   = s1_move;
      cnt_upd.add_en[fsms_pkg::CNT_BIT_OBS]   = s1_move;
      cnt_upd.add_en[fsms_pkg::CNT_SLAT_FF]   = s2_pend_ff;
      cnt_upd.add_en[fsms_pkg::CNT_SLAT_SIM]  = s2_pend_ff;
      cnt_upd.add_en[fsms_pkg::CNT_SLAT_OBS]  = s2_pend_ff;
      cnt_upd.add_en[fsms_pkg::CNT_SPLAT_FF]  = s2_pend_ff;
      cnt_upd.add_en[fsms_pkg::CNT_SPLAT_SIM] = s2_pend_ff;
      cnt_upd.add_en[fsms_pkg::CNT_SPLAT_OBS] = s2_pend_ff;

      cnt_amount = '0;
      cnt_amount[fsms_pkg::CNT_BIT_FF] = fsms_pkg::cnt_type'(
         fsms_pkg::popcount(fsms_pkg::data_type'(sim & s1_obs_ff)));
      cnt_amount[fsms_pkg::CNT_BIT_SIM] = fsms_pkg::cnt_type'(
         fsms_pkg::popcount(fsms_pkg::data_type'(sim & ~s1_obs_ff)));
      cnt_amount[fsms_pkg::CNT_BIT_OBS] = fsms_pkg::cnt_type'(
         fsms_pkg::popcount(fsms_pkg::data_type'(~sim & s1_obs_ff)));
      cnt_amount[fsms_pkg::CNT_SLAT_FF] = fsms_pkg::cnt_type'(
         fsms_pkg::popcount(fsms_pkg::data_type'(s2_slat_ff)));
      cnt_amount[fsms_pkg::CNT_SLAT_SIM] = fsms_pkg::cnt_type'(
         fsms_pkg::popcount(fsms_pkg::data_type'(s2_sim_any_ff & ~s2_slat_ff & s2_vmask_ff)));
      cnt_amount[fsms_pkg::CNT_SLAT_OBS] = fsms_pkg::cnt_type'(
         fsms_pkg::popcount(fsms_pkg::data_type'(s2_obs_any_ff & ~s2_slat_ff & s2_vmask_ff)));
      cnt_amount[fsms_pkg::CNT_SPLAT_FF] = fsms_pkg::cnt_type'(
         fsms_pkg::popcount(fsms_pkg::data_type'(s2_splat_ff)));
      cnt_amount[fsms_pkg::CNT_SPLAT_SIM] = fsms_pkg::cnt_type'(
         fsms_pkg::popcount(fsms_pkg::data_type'(s2_sim_any_ff & ~s2_splat_ff & s2_vmask_ff)));
      cnt_amount[fsms_pkg::CNT_SPLAT_OBS] = fsms_pkg::cnt_type'(
         fsms_pkg::popcount(fsms_pkg::data_type'(s2_obs_any_ff & ~s2_splat_ff & s2_vmask_ff)));
   end

   fsms_counters u_counters (
      .clock  (clock),
      .reset  (reset),
      .upd    (cnt_upd),
      .amount (cnt_amount),
      .total  (cnt_total)
   );

   // result sequencer: next state
   always_comb begin
      s2_kind_in = s2_kind_ff;
      if (s1_move) begin
         s2_kind_in = fsms_pkg::KIND_SIG;
      end else if (out_load && !s2_final) begin
         unique case (s2_kind_ff)
            fsms_pkg::KIND_SIG:    s2_kind_in = fsms_pkg::KIND_SLAT;
            fsms_pkg::KIND_SLAT:   s2_kind_in = fsms_pkg::KIND_SPLAT;
            fsms_pkg::KIND_SPLAT:  s2_kind_in = fsms_pkg::KIND_TOTALS;
            fsms_pkg::KIND_TOTALS: s2_kind_in = fsms_pkg::KIND_TOTALS;
            default:               s2_kind_in = fsms_pkg::KIND_SIG;
         endcase
      end
   end

   // result sequencer: outputs
   always_comb begin
      s2_final    = 1'b0;
      rsp_word_in = '0;
      rsp_cnt_in  = '0;
      unique case (s2_kind_ff)
         fsms_pkg::KIND_SIG: begin
            s2_final    = !s2_last_out_ff;
            rsp_word_in = fsms_pkg::data_type'(s2_sim_ff);
         end
         fsms_pkg::KIND_SLAT: begin
            rsp_word_in = fsms_pkg::data_type'(s2_slat_ff);
         end
         fsms_pkg::KIND_SPLAT: begin
            s2_final    = !s2_last_chk_ff;
            rsp_word_in = fsms_pkg::data_type'(s2_splat_ff);
         end
         fsms_pkg::KIND_TOTALS: begin
            s2_final   = 1'b1;
            rsp_cnt_in = cnt_total;
         end
         default: begin
            s2_final = 1'b1;
         end
      endcase
      rsp_kind_in = s2_kind_ff;
      rsp_last_in = s2_final;
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s2_pend_ff     <= 1'b0;
         s2_kind_ff     <= fsms_pkg::KIND_SIG;
         rsp_valid_ff   <= 1'b0;
         exact_acc_ff   <= '1;
         subset_acc_ff  <= '1;
         sim_any_acc_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         s2_pend_ff     <= s2_pend_in;
         s2_kind_ff     <= s2_kind_in;
         rsp_valid_ff   <= rsp_valid_in;
         exact_acc_ff   <= exact_acc_in;
         subset_acc_ff  <= subset_acc_in;
         sim_any_acc_ff <= sim_any_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_good_ff     <= req_bus.good_word[WORD_BITS-1:0];
         s1_faulty_ff   <= req_bus.faulty_word[WORD_BITS-1:0];
         s1_obs_ff      <= req_bus.observed_word[WORD_BITS-1:0];
         s1_obs_any_ff  <= req_bus.observed_any[WORD_BITS-1:0];
         s1_vmask_ff    <= req_bus.valid_mask[WORD_BITS-1:0];
         s1_last_out_ff <= req_bus.last_output;
         s1_last_chk_ff <= req_bus.last_chunk;
      end
      if (s1_move) begin
         s2_sim_ff      <= sim;
         s2_slat_ff     <= slat_new;
         s2_splat_ff    <= splat_new;
         s2_sim_any_ff  <= sim_any_new;
         s2_obs_any_ff  <= s1_obs_any_ff;
         s2_vmask_ff    <= s1_vmask_ff;
         s2_last_out_ff <= s1_last_out_ff;
         s2_last_chk_ff <= s1_last_chk_ff;
      end
      if (out_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_word_ff <= rsp_word_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.kind            = rsp_kind_ff;
   assign rsp_bus.word            = rsp_word_ff;
   assign rsp_bus.slat_fail_fail  = rsp_cnt_ff[fsms_pkg::CNT_SLAT_FF];
   assign rsp_bus.slat_sim_only   = rsp_cnt_ff[fsms_pkg::CNT_SLAT_SIM];
   assign rsp_bus.slat_obs_only   = rsp_cnt_ff[fsms_pkg::CNT_SLAT_OBS];
   assign rsp_bus.splat_fail_fail = rsp_cnt_ff[fsms_pkg::CNT_SPLAT_FF];
   assign rsp_bus.splat_sim_only  = rsp_cnt_ff[fsms_pkg::CNT_SPLAT_SIM];
   assign rsp_bus.splat_obs_only  = rsp_cnt_ff[fsms_pkg::CNT_SPLAT_OBS];
   assign rsp_bus.bit_fail_fail   = rsp_cnt_ff[fsms_pkg::CNT_BIT_FF];
   assign rsp_bus.bit_sim_only    = rsp_cnt_ff[fsms_pkg::CNT_BIT_SIM];
   assign rsp_bus.bit_obs_only    = rsp_cnt_ff[fsms_pkg::CNT_BIT_OBS];
   assign rsp_bus.last_result     = rsp_last_ff;

   // chunk counts land before a chunk-end item can leave the stage
   a_pend_not_done: assert property (@(posedge clock) disable iff (reset)
      s2_pend_ff |-> !s2_done)
      else $error("chunk counts pending while scoring stage completes");

   // totals are never read while chunk counts are still being added
   a_totals_settled: assert property (@(posedge clock) disable iff (reset)
      (out_load && s2_kind_ff == fsms_pkg::KIND_TOTALS) |-> !s2_pend_ff)
      else $error("totals emitted before chunk counts were added");

   // only a totals result carries counter values
   a_cnt_only_totals: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff != fsms_pkg::KIND_TOTALS) |-> (rsp_cnt_ff == '0))
      else $error("non-totals result carries counter values");

   // the totals result always closes the item
   a_totals_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == fsms_pkg::KIND_TOTALS) |-> rsp_last_ff)
      else $error("totals result without last mark");

endmodule

// File: tb/sv/fail_signature_match_scorer_tb.sv
// self-checking testbench of the fail signature match scorer: directed table, random candidates
module fail_signature_match_scorer_tb;

   localparam fsms_pkg::data_type ONES = '1;
   localparam fsms_pkg::data_type ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam fsms_pkg::data_type ALT_5 = 64'h5555_5555_5555_5555;
   localparam fsms_pkg::data_type MSB = 64'h8000_0000_0000_0000;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_CYCLES = 200;
   localparam int unsigned DRAIN_CYCLES = 16;

   typedef struct {
      fsms_pkg::data_type good;
      fsms_pkg::data_type faulty;
      fsms_pkg::data_type observed;
      fsms_pkg::data_type obs_any;
      fsms_pkg::data_type valid;
      logic               last_out;
      logic               last_chk;
   } chunk_word_type;

   typedef struct {
      fsms_pkg::kind_type    kind;
      fsms_pkg::data_type    word;
      fsms_pkg::cnt_vec_type totals;
      logic                  last;
   } score_type;

   typedef struct {
      fsms_pkg::data_type good;
      fsms_pkg::data_type faulty;
      fsms_pkg::data_type observed;
      fsms_pkg::data_type obs_any;
      fsms_pkg::data_type valid;
      logic               last_out;
      logic               last_chk;
      bit                 typed;
      fsms_pkg::data_type sig;
   } dir_row_type;

   // good, faulty, observed, observed_any, valid, last_output, last_chunk, typed, signature
   dir_row_type directed_rows [16] = '{
      '{'0, '0, '0, '0, ONES, 1'b0, 1'b0, 1'b1, '0},
      '{'0, ONES, ONES, ONES, ONES, 1'b0, 1'b0, 1'b1, ONES},
      '{ONES, ONES, '0, '0, ONES, 1'b0, 1'b0, 1'b1, '0},
      // nothing valid, observed bits outside valid, last_chunk without last_output
      '{'0, ONES, ONES, ONES, '0, 1'b0, 1'b1, 1'b1, '0},
      '{ALT_A, ALT_5, ALT_A, ONES, ONES, 1'b1, 1'b0, 1'b1, ONES},
      '{ONES, '0, ALT_A, ALT_A, ONES, 1'b0, 1'b0, 1'b1, ONES},
      '{'0, ALT_A, ALT_A, ONES, ONES, 1'b0, 1'b0, 1'b1, ALT_A},
      // narrower mask on the chunk's last item
      '{'0, ALT_5, '0, ALT_5, 64'hFFFF_FFFF_0000_0000, 1'b1, 1'b1, 1'b1,
        64'h5555_5555_0000_0000},
      '{'0, ONES, ONES, ONES, ONES, 1'b1, 1'b1, 1'b1, ONES},
      '{'0, 64'h1, 64'h1, 64'h1, 64'h1, 1'b1, 1'b1, 1'b1, 64'h1},
      '{'0, MSB, '0, MSB, MSB, 1'b1, 1'b1, 1'b1, MSB},
      '{'0, '0, ONES, ONES, ONES, 1'b1, 1'b1, 1'b1, '0},
      '{64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CD00, 64'hEF, 64'h0F0F_0000_0000_00EF,
        ONES, 1'b0, 1'b0, 1'b0, '0},
      '{64'hDEAD_BEEF_0000_0000, 64'hDEAD_0000_0000_0000, 64'hBEEF_0000_0000,
        64'hBEEF_0000_00FF, ONES, 1'b0, 1'b0, 1'b0, '0},
      '{64'hFEED_FACE_CAFE_F00D, 64'hFEED_FACE_CAFE_F00D, 64'h1, 64'hBEEF_0000_00FF,
        64'h00FF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, '0},
      '{ONES, 64'h7FFF_FFFF_FFFF_FFFE, ONES, ONES, ONES, 1'b1, 1'b1, 1'b0, '0}
   };

   string cnt_label [fsms_pkg::NUM_CNT] = '{
      "slat_fail_fail", "slat_sim_only", "slat_obs_only",
      "splat_fail_fail", "splat_sim_only", "splat_obs_only",
      "bit_fail_fail", "bit_sim_only", "bit_obs_only"
   };

   logic clock = 1'b0;
   logic reset;

   fsms_req_if req_bus ();
   fsms_rsp_if rsp_bus ();

   fail_signature_match_scorer DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scoring state of the candidate under test
   fsms_pkg::data_type    match_exact = '1;
   fsms_pkg::data_type    match_subset = '1;
   fsms_pkg::data_type    sim_any = '0;
   fsms_pkg::cnt_vec_type tally = '0;
   score_type             pending_scores [$];

   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned words_sent = 0;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned hold_req = 0;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic fsms_pkg::data_type rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic fsms_pkg::data_type sparse64();
      return rand64() & rand64() & rand64();
   endfunction

   function automatic fsms_pkg::cnt_type sat_add(input fsms_pkg::cnt_type cur,
                                                 input int unsigned amt);
      if (amt >= fsms_pkg::CNT_MAX - cur) begin
         return fsms_pkg::CNT_MAX;
      end
      return cur + fsms_pkg::cnt_type'(amt);
   endfunction

   function automatic score_type mk_score(input fsms_pkg::kind_type k,
                                          input fsms_pkg::data_type wd, input logic lst);
      score_type s;
      s.kind = k;
      s.word = wd;
      s.totals = '0;
      s.last = lst;
      return s;
   endfunction

   task automatic queue_score(input score_type s);
      pending_scores.insert(pending_scores.size(), s);
   endtask

   // folds one accepted item into the state and queues the results it causes
   task automatic score_word(input chunk_word_type w, input bit typed,
                             input fsms_pkg::data_type sig_typed);
      fsms_pkg::data_type sim;
      fsms_pkg::data_type exact;
      fsms_pkg::data_type subset;
      fsms_pkg::data_type slat;
      fsms_pkg::data_type splat;
      score_type          s;
      sim = (w.good ^ w.faulty) & w.valid;
      match_exact &= ~(sim ^ w.observed);
      match_subset &= ~(sim & ~w.observed);
      sim_any |= sim;
      tally[fsms_pkg::CNT_BIT_FF] = sat_add(tally[fsms_pkg::CNT_BIT_FF],
                                            $countones(sim & w.observed));
      tally[fsms_pkg::CNT_BIT_SIM] = sat_add(tally[fsms_pkg::CNT_BIT_SIM],
                                             $countones(sim & ~w.observed));
      tally[fsms_pkg::CNT_BIT_OBS] = sat_add(tally[fsms_pkg::CNT_BIT_OBS],
                                             $countones(~sim & w.observed));
      queue_score(mk_score(fsms_pkg::KIND_SIG, typed ? sig_typed : sim, !w.last_out));
      if (w.last_out) begin
         exact = match_exact & w.valid;
         subset = match_subset & w.valid;
         slat = exact & w.obs_any & sim_any;
         splat = subset & w.obs_any & sim_any;
         tally[fsms_pkg::CNT_SLAT_FF] = sat_add(tally[fsms_pkg::CNT_SLAT_FF],
                                                $countones(slat));
         tally[fsms_pkg::CNT_SLAT_SIM] = sat_add(tally[fsms_pkg::CNT_SLAT_SIM],
                                                 $countones(sim_any & ~slat & w.valid));
         tally[fsms_pkg::CNT_SLAT_OBS] = sat_add(tally[fsms_pkg::CNT_SLAT_OBS],
                                                 $countones(w.obs_any & ~slat & w.valid));
         tally[fsms_pkg::CNT_SPLAT_FF] = sat_add(tally[fsms_pkg::CNT_SPLAT_FF],
                                                 $countones(splat));
         tally[fsms_pkg::CNT_SPLAT_SIM] = sat_add(tally[fsms_pkg::CNT_SPLAT_SIM],
                                                  $countones(sim_any & ~splat & w.valid));
         tally[fsms_pkg::CNT_SPLAT_OBS] = sat_add(tally[fsms_pkg::CNT_SPLAT_OBS],
                                                  $countones(w.obs_any & ~splat & w.valid));
         queue_score(mk_score(fsms_pkg::KIND_SLAT, slat, 1'b0));
         queue_score(mk_score(fsms_pkg::KIND_SPLAT, splat, !w.last_chk));
         match_exact = '1;
         match_subset = '1;
         sim_any = '0;
         if (w.last_chk) begin
            s = mk_score(fsms_pkg::KIND_TOTALS, '0, 1'b1);
            s.totals = tally;
            queue_score(s);
            tally = '0;
         end
      end
   endtask

   task automatic send_word(input chunk_word_type w, input bit typed,
                            input fsms_pkg::data_type sig_typed);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.good_word <= w.good;
      req_bus.faulty_word <= w.faulty;
      req_bus.observed_word <= w.observed;
      req_bus.observed_any <= w.obs_any;
      req_bus.valid_mask <= w.valid;
      req_bus.last_output <= w.last_out;
      req_bus.last_chunk <= w.last_chk;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      score_word(w, typed, sig_typed);
      words_sent++;
   endtask

   // one well-formed candidate whose observed fails mostly track the simulated ones
   task automatic send_candidate(input int n_chunks, input int min_outs, input int max_outs);
      chunk_word_type     outs [$];
      chunk_word_type     w;
      fsms_pkg::data_type valid;
      fsms_pkg::data_type union_obs;
      fsms_pkg::data_type obs_any;
      fsms_pkg::data_type sim_t;
      int                 n_out;
      for (int c = 0; c < n_chunks; c++) begin
         outs.delete();
         union_obs = '0;
         case ($urandom_range(7))
            5: valid = rand64();
            6: valid = ONES >> $urandom_range(63);
            7: valid = ONES << $urandom_range(63);
            default: valid = ONES;
         endcase
         n_out = $urandom_range(max_outs, min_outs);
         for (int o = 0; o < n_out; o++) begin
            w.good = rand64();
            sim_t = ($urandom_range(3) == 0) ? rand64() : sparse64();
            w.faulty = w.good ^ sim_t;
            case ($urandom_range(9))
               6: w.observed = sim_t & valid & rand64();
               7: w.observed = (sim_t & valid) | sparse64();
               8: w.observed = '0;
               9: w.observed = rand64();
               default: w.observed = sim_t & valid;
            endcase
            w.valid = valid;
            w.last_out = (o == n_out - 1);
            w.last_chk = w.last_out && (c == n_chunks - 1);
            union_obs |= w.observed;
            outs.insert(outs.size(), w);
         end
         case ($urandom_range(9))
            8: obs_any = union_obs | sparse64();
            9: obs_any = rand64();
            default: obs_any = union_obs;
         endcase
         foreach (outs[i]) begin
            w = outs[i];
            w.obs_any = obs_any;
            send_word(w, 1'b0, '0);
         end
      end
   endtask

   task automatic run_random(input int unsigned until_count);
      chunk_word_type w;
      while (words_sent < until_count) begin
         if ($urandom_range(4) != 0) begin
            send_candidate($urandom_range(4, 1), 1, 6);
         end else begin
            // noise: fully random items, chunk and candidate ends wherever they fall
            repeat ($urandom_range(4, 1)) begin
               w.good = rand64();
               w.faulty = rand64();
               w.observed = rand64();
               w.obs_any = rand64();
               w.valid = rand64();
               w.last_out = 1'($urandom_range(1));
               w.last_chk = 1'($urandom_range(1));
               send_word(w, 1'b0, '0);
            end
         end
      end
   endtask

   // receiver: random stalls plus a single long hold-off
   initial begin
      int unsigned hold_left;
      int unsigned hold_done;
      hold_left = 0;
      hold_done = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_req != hold_done) begin
            hold_done = hold_req;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      score_type             want;
      fsms_pkg::cnt_vec_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_scores.size() == 0) begin
            report_mismatch("result with nothing pending");
         end else begin
            want = pending_scores.pop_front();
            got = {rsp_bus.bit_obs_only, rsp_bus.bit_sim_only, rsp_bus.bit_fail_fail,
                   rsp_bus.splat_obs_only, rsp_bus.splat_sim_only, rsp_bus.splat_fail_fail,
                   rsp_bus.slat_obs_only, rsp_bus.slat_sim_only, rsp_bus.slat_fail_fail};
            if (rsp_bus.kind !== want.kind) begin
               report_mismatch($sformatf("kind %0d, want %0d", rsp_bus.kind, want.kind));
            end
            if (rsp_bus.word !== want.word) begin
               report_mismatch($sformatf("word %h, want %h", rsp_bus.word, want.word));
            end
            for (int i = 0; i < fsms_pkg::NUM_CNT; i++) begin
               if (got[i] !== want.totals[i]) begin
                  report_mismatch($sformatf("%s %0d, want %0d", cnt_label[i], got[i],
                                            want.totals[i]));
               end
            end
            if (rsp_bus.last_result !== want.last) begin
               report_mismatch($sformatf("last_result %b, want %b", rsp_bus.last_result,
                                         want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fail_signature_match_scorer_tb: errors");
         $finish;
      end
   end

   initial begin
      chunk_word_type w;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.good_word = '0;
      req_bus.faulty_word = '0;
      req_bus.observed_word = '0;
      req_bus.observed_any = '0;
      req_bus.valid_mask = '0;
      req_bus.last_output = 1'b0;
      req_bus.last_chunk = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 37;
      rsp_idle_pct = 59;
      foreach (directed_rows[i]) begin
         w.good = directed_rows[i].good;
         w.faulty = directed_rows[i].faulty;
         w.observed = directed_rows[i].observed;
         w.obs_any = directed_rows[i].obs_any;
         w.valid = directed_rows[i].valid;
         w.last_out = directed_rows[i].last_out;
         w.last_chk = directed_rows[i].last_chk;
         send_word(w, directed_rows[i].typed, directed_rows[i].sig);
      end
      run_random(110);

      req_idle_pct = 59;
      rsp_idle_pct = 37;
      run_random(220);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_req++;
      run_random(330);
      req_bus.valid <= 1'b0;

      while (pending_scores.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("fail_signature_match_scorer_tb: clean");
      end else begin
         $display("fail_signature_match_scorer_tb: errors");
      end
      $finish;
   end

endmodule

// File: files.f
src/fsms_pkg.sv
src/fsms_if.sv
src/fsms_counters.sv
src/fail_signature_match_scorer.sv
tb/sv/fail_signature_match_scorer_tb.sv
